/* rtl/battery_soc_estimator_unit_macros.svh */
// Assertion macros for the battery SOC estimator.
// Each use expects clk and rst to be in scope.
`ifndef BATTERY_SOC_ESTIMATOR_UNIT_MACROS_SVH
`define BATTERY_SOC_ESTIMATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define BSOC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bsoc check failed");
`define BSOC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsoc check failed");
`else
`define BSOC_ASSERT(lbl, cond)
`define BSOC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/bsoc_pkg.sv */
// ---------------------------------------------------------------------------
// bsoc_pkg
// Shared types, curve table and codes of the battery SOC estimator.
// ---------------------------------------------------------------------------
package bsoc_pkg;
  localparam int MV_W = 14;
  localparam int NUM_SAMPLES = 5;
  localparam int CURVE_POINTS = 21;
  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 9;
  localparam int PCT_W = 7;
  localparam int SM_W = 15;

  // divide by 100 as multiply by ceil(2^29/100) then shift; exact below 2^22
  localparam int RECIP_W = 23;
  localparam int EMA_SHIFT = 29;
  localparam logic [RECIP_W-1:0] EMA_RECIP = 23'd5368710;

  // open-circuit-voltage curve, descending
  localparam logic [MV_W-1:0] CURVE_MV [0:CURVE_POINTS-1] = '{
    14'd4200, 14'd4150, 14'd4110, 14'd4080, 14'd4020, 14'd3980, 14'd3950,
    14'd3910, 14'd3870, 14'd3850, 14'd3840, 14'd3820, 14'd3800, 14'd3790,
    14'd3770, 14'd3750, 14'd3730, 14'd3710, 14'd3690, 14'd3610, 14'd3300};
  localparam logic [PCT_W-1:0] CURVE_PCT [0:CURVE_POINTS-1] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60, 7'd55,
    7'd50, 7'd45, 7'd40, 7'd35, 7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0};

  // battery state codes
  localparam logic [1:0] BS_NONE     = 2'd0;
  localparam logic [1:0] BS_IDLE     = 2'd1;
  localparam logic [1:0] BS_CHARGING = 2'd2;
  localparam logic [1:0] BS_FULL     = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ALPHA    = 3'd0;
  localparam logic [2:0] REG_CHARGING = 3'd1;
  localparam logic [2:0] REG_FULL     = 3'd2;
  localparam logic [2:0] REG_PRESENT  = 3'd3;
  localparam logic [2:0] REG_RISE     = 3'd4;
  localparam logic [2:0] REG_FALL     = 3'd5;
  localparam logic [2:0] REG_FREEZE   = 3'd6;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;
endpackage

/* rtl/bsoc_ram.sv */
// ---------------------------------------------------------------------------
// bsoc_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bsoc_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/bsoc_rank_lane.sv */
// ---------------------------------------------------------------------------
// bsoc_rank_lane
// One median lane: rank of its own reading among the good readings.
// ---------------------------------------------------------------------------
module bsoc_rank_lane #(
  parameter int IDX = 0
) (
  input  logic [bsoc_pkg::NUM_SAMPLES-1:0][bsoc_pkg::MV_W-1:0] vals,
  input  logic [2:0]                                           good,
  output logic [2:0]                                           rank
);
  import bsoc_pkg::*;

  // stable ordering: ties broken by lane position
  always_comb begin
    rank = 3'd0;
    for (int j = 0; j < NUM_SAMPLES; j++) begin
      if ((3'(j) < good) && ((vals[j] < vals[IDX]) ||
          ((vals[j] == vals[IDX]) && (j < IDX)))) begin
        rank = rank + 3'd1;
      end
    end
  end
endmodule

/* rtl/bsoc_div.sv */
// ---------------------------------------------------------------------------
// bsoc_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bsoc_div (
  input  logic               clk,
  input  logic               rst,
  input  bsoc_pkg::div_req_t req,
  output bsoc_pkg::div_rsp_t rsp
);
  import bsoc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0]         rem;
  logic [DIV_NUM_W-1:0]         quo;
  logic [DIV_DEN_W-1:0]         den;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic                         done;
  logic [DIV_DEN_W:0]           rem_sh;
  logic                         ge;

  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign ge = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == CNT_W'(DIV_NUM_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        quo <= req.num;
        den <= req.den;
      end else if (busy) begin
        quo <= {quo[DIV_NUM_W-2:0], ge};
        rem <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DIV_DEN_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = '{done: done, quo: quo};
endmodule

/* rtl/battery_soc_estimator_unit.sv */
// A failed reading goes from the rank state straight to output; a good one passes
// ring write, trend, segment search, the 22-bit bit-serial curve divider (most of
// its time), smoothing and freeze window; the smoothing multiply is skipped on the
// first poll after reset or a failed reading. One item at a time: the next item is
// taken the cycle after the result is loaded, later while out_stall holds it.
// Reset (rst, synchronous): registers to defaults, control state cleared;
// the trend ring is not cleared, its fill count guards every read.
// ---------------------------------------------------------------------------
// battery_soc_estimator_unit
// Median of good readings across rank lanes, trend ring, charging latch,
// OCV curve interpolation, Q7.8 moving average and freeze window.
// ---------------------------------------------------------------------------
`include "battery_soc_estimator_unit_macros.svh"
module battery_soc_estimator_unit #(
  parameter int TREND_DEPTH = 30,
  parameter int SAMPLES_PER_POLL = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  // config write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  // input item channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [13:0]              sample_a_mv,
  input  logic [13:0]              sample_b_mv,
  input  logic [13:0]              sample_c_mv,
  input  logic [13:0]              sample_d_mv,
  input  logic [13:0]              sample_e_mv,
  input  logic [2:0]               good_count,
  input  logic [31:0]              time_ms,
  // result item channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     reading_ok,
  output logic [13:0]              battery_mv,
  output logic                     charger_on,
  output logic [1:0]               battery_state,
  output logic signed [7:0]        soc_pct,
  output logic                     frozen
);
  import bsoc_pkg::*;

  localparam int HEAD_W = $clog2(TREND_DEPTH);
  localparam int FILL_W = $clog2(TREND_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RANK  = 4'd1;
  localparam logic [3:0] S_RING  = 4'd2;
  localparam logic [3:0] S_TREND = 4'd3;
  localparam logic [3:0] S_SEG   = 4'd4;
  localparam logic [3:0] S_DIV1  = 4'd5;
  localparam logic [3:0] S_EMA   = 4'd6;
  localparam logic [3:0] S_EMA2  = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration registers
  logic [6:0]         ema_alpha_pct;
  logic [13:0]        charging_mv;
  logic [13:0]        full_mv;
  logic [13:0]        present_min_mv;
  logic [9:0]         trend_rise_mv;
  logic signed [10:0] trend_fall_mv;
  logic [31:0]        freeze_ms;

  // estimator state
  logic [3:0]         state;
  logic [HEAD_W-1:0]  ring_head;
  logic [FILL_W-1:0]  ring_fill;
  logic               charge_latch;
  logic [SM_W-1:0]    smoothed_soc;
  logic               smoothed_valid;
  logic [1:0]         last_state;
  logic               last_state_known;
  logic [31:0]        change_time;
  logic               freeze_armed;
  logic signed [7:0]  published_soc;

  // per-item working registers
  logic [NUM_SAMPLES-1:0][MV_W-1:0] smp;
  logic [2:0]         good;
  logic [31:0]        now;
  logic [MV_W-1:0]    median;
  logic [1:0]         bstate;
  logic [4:0]         seg;
  logic               seg_hit;
  logic [PCT_W-1:0]   pct;
  logic [DIV_NUM_W-1:0] prod_a;
  logic [DIV_NUM_W-1:0] prod_b;
  logic [DIV_NUM_W-1:0] ema_sum;

  // result fields waiting for the output register
  logic               res_ok;
  logic [MV_W-1:0]    res_mv;
  logic               res_chg;
  logic [1:0]         res_st;
  logic               res_frz;

  // rank lanes and median merge
  logic [NUM_SAMPLES-1:0][2:0] rank;
  logic [MV_W-1:0]    med_pick;

  // ring memory
  logic [HEAD_W-1:0]  head_inc;
  logic [MV_W-1:0]    ring_old;

  div_req_t           dreq;
  div_rsp_t           drsp;

  // combinational helpers
  logic [4:0]         seg_c;
  logic               hit_c;
  logic signed [14:0] delta;
  logic               latch_c;
  logic [SM_W-1:0]    sm_round;
  logic [PCT_W+1:0]   pct_s;
  logic [31:0]        diff;
  logic [MV_W-1:0]    lo_mv;
  logic [DIV_NUM_W+RECIP_W-1:0] ema_prod;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_alpha_pct  <= 7'd35;
      charging_mv    <= 14'd4150;
      full_mv        <= 14'd4200;
      present_min_mv <= 14'd2500;
      trend_rise_mv  <= 10'd10;
      trend_fall_mv  <= -11'sd5;
      freeze_ms      <= 32'd60000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA:    ema_alpha_pct  <= cfg_data[6:0];
        REG_CHARGING: charging_mv    <= cfg_data[13:0];
        REG_FULL:     full_mv        <= cfg_data[13:0];
        REG_PRESENT:  present_min_mv <= cfg_data[13:0];
        REG_RISE:     trend_rise_mv  <= cfg_data[9:0];
        REG_FALL:     trend_fall_mv  <= $signed(cfg_data[10:0]);
        REG_FREEZE:   freeze_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_lane
    bsoc_rank_lane #(.IDX(g)) u_lane (
      .vals (smp),
      .good (good),
      .rank (rank[g])
    );
  end

  // the good lane whose rank is the middle one holds the median
  always_comb begin
    med_pick = '0;
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      if ((3'(k) < good) && (rank[k] == (good >> 1))) begin
        med_pick = smp[k];
      end
    end
  end

  assign head_inc = (ring_head == HEAD_W'(TREND_DEPTH - 1)) ? '0 : ring_head + 1'b1;

  bsoc_ram #(.WIDTH(MV_W), .DEPTH(TREND_DEPTH)) u_ring (
    .clk   (clk),
    .we    (state == S_RING),
    .waddr (ring_head),
    .wdata (median),
    .raddr (head_inc),
    .rdata (ring_old)
  );

  bsoc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // trend against the oldest ring entry, and curve segment search
  always_comb begin
    delta = $signed({1'b0, median}) - $signed({1'b0, ring_old});
    latch_c = charge_latch;
    if (median >= charging_mv) begin
      latch_c = 1'b1;
    end else if (ring_fill >= FILL_W'(TREND_DEPTH)) begin
      if (delta >= $signed({5'd0, trend_rise_mv})) begin
        latch_c = 1'b1;
      end else if (delta <= 15'(trend_fall_mv)) begin
        latch_c = 1'b0;
      end
    end
    seg_c = '0;
    hit_c = 1'b0;
    for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
      if (median >= CURVE_MV[i+1]) begin
        seg_c = 5'(i);
        hit_c = 1'b1;
      end
    end
  end

  assign lo_mv    = CURVE_MV[seg + 5'd1];
  assign sm_round = smoothed_soc + SM_W'(128);
  assign pct_s    = {2'b00, sm_round[SM_W-1:8]};
  assign diff     = now - change_time;
  // Q7.8 sum divided by 100
  assign ema_prod = ema_sum * EMA_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ring_head        <= '0;
      ring_fill        <= '0;
      charge_latch     <= 1'b0;
      smoothed_valid   <= 1'b0;
      smoothed_soc     <= '0;
      last_state       <= BS_NONE;
      last_state_known <= 1'b0;
      change_time      <= '0;
      freeze_armed     <= 1'b0;
      published_soc    <= -8'sd1;
      out_valid        <= 1'b0;
      dreq.start       <= 1'b0;
    end else begin
      // curve divide starts as the segment is resolved
      dreq.start <= (state == S_SEG);
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            smp  <= {sample_e_mv, sample_d_mv, sample_c_mv, sample_b_mv, sample_a_mv};
            good <= (good_count > 3'(SAMPLES_PER_POLL)) ? 3'(SAMPLES_PER_POLL)
                                                         : good_count;
            now  <= time_ms;
            state <= S_RANK;
          end
        end
        S_RANK: begin
          if (good < 3'd3) begin
            // failed reading: drop smoothing and state memory
            smoothed_valid   <= 1'b0;
            last_state_known <= 1'b0;
            published_soc    <= -8'sd1;
            res_ok  <= 1'b0;
            res_mv  <= '0;
            res_chg <= 1'b0;
            res_st  <= BS_NONE;
            res_frz <= 1'b0;
            state <= S_OUT;
          end else begin
            median <= med_pick;
            state <= S_RING;
          end
        end
        S_RING: begin
          ring_head <= head_inc;
          if (ring_fill < FILL_W'(TREND_DEPTH)) begin
            ring_fill <= ring_fill + 1'b1;
          end
          state <= S_TREND;
        end
        S_TREND: begin
          charge_latch <= latch_c;
          if (median < present_min_mv) begin
            bstate <= BS_NONE;
          end else if (latch_c && median >= full_mv) begin
            bstate <= BS_FULL;
          end else if (latch_c) begin
            bstate <= BS_CHARGING;
          end else begin
            bstate <= BS_IDLE;
          end
          seg <= seg_c;
          seg_hit <= hit_c;
          state <= S_SEG;
        end
        S_SEG: begin
          if (median >= CURVE_MV[0]) begin
            pct <= CURVE_PCT[0];
            dreq.num <= '0;
            dreq.den <= DIV_DEN_W'(1);
          end else if (!seg_hit) begin
            pct <= CURVE_PCT[CURVE_POINTS-1];
            dreq.num <= '0;
            dreq.den <= DIV_DEN_W'(1);
          end else begin
            pct <= CURVE_PCT[seg + 5'd1];
            dreq.num <= DIV_NUM_W'((median - lo_mv) *
                                   (CURVE_PCT[seg] - CURVE_PCT[seg + 5'd1]));
            dreq.den <= DIV_DEN_W'(CURVE_MV[seg] - lo_mv);
          end
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (drsp.done) begin
            pct <= pct + drsp.quo[PCT_W-1:0];
            state <= S_EMA;
          end
        end
        S_EMA: begin
          if (!smoothed_valid) begin
            smoothed_soc <= {pct, 8'd0};
            smoothed_valid <= 1'b1;
            state <= S_FIN;
          end else begin
            prod_a <= DIV_NUM_W'(((ema_alpha_pct > 7'd100) ? 7'd100 : ema_alpha_pct)
                                 * {pct, 8'd0});
            prod_b <= DIV_NUM_W'((7'd100 - ((ema_alpha_pct > 7'd100) ? 7'd100
                                 : ema_alpha_pct)) * smoothed_soc);
            state <= S_EMA2;
          end
        end
        S_EMA2: begin
          ema_sum <= prod_a + prod_b + DIV_NUM_W'(50);
          state <= S_SCALE;
        end
        S_SCALE: begin
          smoothed_soc <= ema_prod[EMA_SHIFT+SM_W-1:EMA_SHIFT];
          state <= S_FIN;
        end
        S_FIN: begin
          // freeze window; a fresh change restarts it at this poll's time
          last_state <= bstate;
          last_state_known <= 1'b1;
          res_ok  <= 1'b1;
          res_mv  <= median;
          res_chg <= charge_latch;
          res_st  <= bstate;
          if (last_state_known && bstate != last_state) begin
            change_time <= now;
            res_frz <= (freeze_ms != 32'd0);
            freeze_armed <= (freeze_ms != 32'd0);
            if (freeze_ms == 32'd0) begin
              published_soc <= (median >= full_mv || pct_s > 9'd100) ? 8'sd100
                                                                     : 8'(pct_s);
            end
          end else if (freeze_armed && diff < freeze_ms) begin
            res_frz <= 1'b1;
          end else begin
            res_frz <= 1'b0;
            freeze_armed <= 1'b0;
            published_soc <= (median >= full_mv || pct_s > 9'd100) ? 8'sd100
                                                                   : 8'(pct_s);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // load the output register once the previous result has left
          if (!out_valid || !out_stall) begin
            reading_ok    <= res_ok;
            battery_mv    <= res_mv;
            charger_on    <= res_chg;
            battery_state <= res_st;
            soc_pct       <= published_soc;
            frozen        <= res_frz;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BSOC_ASSERT(a_fill_bound, ring_fill <= FILL_W'(TREND_DEPTH))
  `BSOC_ASSERT(a_head_bound, ring_head <= HEAD_W'(TREND_DEPTH - 1))
  `BSOC_ASSERT(a_fail_result, !(out_valid && !reading_ok) || (soc_pct == -8'sd1 && !frozen))
  `BSOC_ASSERT(a_frozen_ok, !(out_valid && frozen) || reading_ok)
  `BSOC_ASSERT_NEXT(a_div_busy, dreq.start, state == S_DIV1)
endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for battery_soc_estimator_unit: median, trend latch,
// OCV curve, Q7.8 smoothing and freeze window, under random idle and stall.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsoc_pkg::*;

  // index past the register list, must be ignored
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [13:0] mv;
    logic        chg;
    logic [1:0]  st;
    logic [7:0]  pct;
    logic        frz;
  } soc_result_t;

  typedef struct {
    logic [13:0] smp [5];
    logic [2:0]  good;
    logic [31:0] now;
  } poll_t;

  // Scoreboard: own copy of the estimator state and registers, plus the
  // queue of results still owed by the block.
  class soc_scoreboard;
    logic [6:0]  alpha_r;
    logic [13:0] chg_mv_r, full_mv_r, present_r;
    logic [9:0]  rise_r;
    logic [10:0] fall_r;
    logic [31:0] freeze_r;
    logic [13:0] trend [30];
    int          head, fill;
    bit          latch, sm_valid, st_known, armed;
    int unsigned sm;
    logic [1:0]  last_st;
    logic [31:0] chg_time;
    int          published;
    soc_result_t owed [$];
    int          errors;

    function new();
      alpha_r = 35; chg_mv_r = 4150; full_mv_r = 4200; present_r = 2500;
      rise_r = 10; fall_r = 11'h7FB; freeze_r = 60000;
      head = 0; fill = 0; latch = 0; sm_valid = 0; st_known = 0; armed = 0;
      sm = 0; last_st = BS_NONE; chg_time = 0; published = -1; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_ALPHA:    alpha_r = d[6:0];
        REG_CHARGING: chg_mv_r = d[13:0];
        REG_FULL:     full_mv_r = d[13:0];
        REG_PRESENT:  present_r = d[13:0];
        REG_RISE:     rise_r = d[9:0];
        REG_FALL:     fall_r = d[10:0];
        REG_FREEZE:   freeze_r = d;
        default: ;
      endcase
    endfunction

    function int unsigned curve_pct(int unsigned mv);
      int unsigned hi, lo;
      if (mv >= CURVE_MV[0]) return CURVE_PCT[0];
      for (int i = 0; i + 1 < CURVE_POINTS; i++) begin
        hi = CURVE_MV[i]; lo = CURVE_MV[i+1];
        if (mv <= hi && mv >= lo)
          return CURVE_PCT[i+1] + (mv - lo) * (CURVE_PCT[i] - CURVE_PCT[i+1]) / (hi - lo);
      end
      return 0;
    endfunction

    function void note_poll(poll_t p);
      int unsigned v [5];
      int unsigned g, med, pct, a, ps, tmp;
      int          delta, fall;
      logic [1:0]  st;
      logic [31:0] diff;
      bit          hold;
      soc_result_t r;
      g = (p.good > 5) ? 5 : p.good;
      if (g < 3) begin
        sm_valid = 0; st_known = 0; published = -1;
        r = '{ok: 0, mv: 0, chg: 0, st: BS_NONE, pct: 8'hFF, frz: 0};
        owed.push_back(r);
        return;
      end
      for (int i = 0; i < 5; i++) v[i] = p.smp[i];
      for (int i = 1; i < g; i++)
        for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
          tmp = v[j]; v[j] = v[j-1]; v[j-1] = tmp;
        end
      med = v[g/2];
      trend[head] = med;
      head = (head + 1) % 30;
      if (fill < 30) fill++;
      if (med >= chg_mv_r) latch = 1;
      else if (fill >= 30) begin
        fall = $signed(fall_r);
        delta = int'(med) - int'(trend[head]);
        if (delta >= int'(rise_r)) latch = 1;
        else if (delta <= fall) latch = 0;
      end
      if (med < present_r) st = BS_NONE;
      else if (latch && med >= full_mv_r) st = BS_FULL;
      else if (latch) st = BS_CHARGING;
      else st = BS_IDLE;
      pct = curve_pct(med);
      a = (alpha_r > 100) ? 100 : alpha_r;
      if (!sm_valid) begin
        sm = pct << 8; sm_valid = 1;
      end else sm = (a * (pct << 8) + (100 - a) * sm + 50) / 100;
      ps = (sm + 128) >> 8;
      if (med >= full_mv_r || ps > 100) ps = 100;
      if (st_known && st != last_st) begin
        chg_time = p.now; armed = 1;
      end
      last_st = st; st_known = 1;
      hold = 0;
      if (armed) begin
        diff = p.now - chg_time;
        if (diff < freeze_r) hold = 1;
        else armed = 0;
      end
      if (!hold) published = ps;
      r = '{ok: 1, mv: med[13:0], chg: latch, st: st, pct: published[7:0], frz: hold};
      owed.push_back(r);
    endfunction

    function void check_result(soc_result_t got);
      soc_result_t e;
      if (owed.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.ok !== e.ok) begin $error("reading_ok exp %0d got %0d", e.ok, got.ok); errors++; end
      if (got.mv !== e.mv) begin $error("battery_mv exp %0d got %0d", e.mv, got.mv); errors++; end
      if (got.chg !== e.chg) begin
        $error("charger_on exp %0d got %0d", e.chg, got.chg); errors++;
      end
      if (got.st !== e.st) begin
        $error("battery_state exp %0d got %0d", e.st, got.st); errors++;
      end
      if (got.pct !== e.pct) begin
        $error("soc_pct exp %0d got %0d", $signed(e.pct), $signed(got.pct)); errors++;
      end
      if (got.frz !== e.frz) begin $error("frozen exp %0d got %0d", e.frz, got.frz); errors++; end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic [13:0] sample_a_mv, sample_b_mv, sample_c_mv, sample_d_mv, sample_e_mv;
  logic [2:0]  good_count;
  logic [31:0] time_ms;
  logic        out_valid, out_stall;
  logic        reading_ok, charger_on, frozen;
  logic [13:0] battery_mv;
  logic [1:0]  battery_state;
  logic signed [7:0] soc_pct;

  battery_soc_estimator_unit dut (.*);

  soc_scoreboard sb = new();
  int          send_idle_pct, recv_idle_pct;   // idle odds, in percent
  logic [31:0] clock_ms;                       // running poll time
  poll_t       cur;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stall, result taken on valid && !stall.
  initial begin
    out_stall = 1;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result('{reading_ok, battery_mv, charger_on, battery_state, soc_pct, frozen});
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Send one poll; idle cycles before it per the sender odds.
  task automatic send_poll(poll_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sample_a_mv <= p.smp[0]; sample_b_mv <= p.smp[1]; sample_c_mv <= p.smp[2];
    sample_d_mv <= p.smp[3]; sample_e_mv <= p.smp[4];
    good_count <= p.good; time_ms <= p.now;
    do @(posedge clk); while (in_stall);
    sb.note_poll(p);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Mostly near the curve and thresholds, sometimes full range.
  function automatic logic [13:0] rand_mv(int unsigned base);
    case ($urandom_range(9))
      0: return 14'($urandom_range(9300));
      1: return 14'($urandom_range(16383));
      default: return 14'(base + $urandom_range(60) - 30);
    endcase
  endfunction

  task automatic rand_polls(int n);
    int unsigned base;
    base = 3800;
    repeat (n) begin
      if ($urandom_range(19) == 0) base = $urandom_range(3200, 4300);
      else base = base + $urandom_range(16) - 8;
      for (int i = 0; i < 5; i++) cur.smp[i] = rand_mv(base);
      cur.good = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3, 5));
      if ($urandom_range(49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(20000);
      cur.now = clock_ms;
      send_poll(cur);
    end
  endtask

  task automatic directed(logic [13:0] a, logic [13:0] b, logic [13:0] c,
                          logic [13:0] d, logic [13:0] e, logic [2:0] g,
                          logic [31:0] t);
    cur.smp = '{a, b, c, d, e}; cur.good = g; cur.now = t;
    send_poll(cur);
  endtask

  initial begin
    rst = 1; cfg_valid = 0; cfg_index = REG_ALPHA; cfg_data = 0;
    in_valid = 0; sample_a_mv = 0; sample_b_mv = 0; sample_c_mv = 0;
    sample_d_mv = 0; sample_e_mv = 0; good_count = 0; time_ms = 0;
    send_idle_pct = 0; recv_idle_pct = 0; clock_ms = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: failed reading, count clamp, even count, curve ends, freeze.
    directed(14'd4000, 14'd4000, 14'd0, 14'd0, 14'd0, 3'd2, 0);
    directed(14'd9300, 14'd0, 14'd3300, 14'd0, 14'd0, 3'd3, 10);
    directed(14'd3700, 14'd3900, 14'd3800, 14'd3850, 14'd16383, 3'd4, 20);
    directed(14'd4200, 14'd4300, 14'd4250, 14'd4210, 14'd4220, 3'd5, 30);
    directed(14'd3299, 14'd3299, 14'd3299, 14'd3299, 14'd3299, 3'd7, 40);
    directed(14'd2400, 14'd2400, 14'd2400, 14'd9300, 14'd0, 3'd6, 50);
    directed(14'd3850, 14'd3850, 14'd3850, 14'd3850, 14'd3850, 3'd5, 32'hFFFF_FFF0);
    directed(14'd3610, 14'd3610, 14'd3610, 14'd0, 14'd0, 3'd3, 32'h0000_0100);
    directed(14'd16383, 14'd16383, 14'd16383, 14'd16383, 14'd16383, 3'd5, 32'h0001_0000);
    directed(14'd3750, 14'd3760, 14'd3740, 14'd0, 14'd0, 3'd0, 32'h0002_0000);
    directed(14'd3750, 14'd3760, 14'd3740, 14'd0, 14'd0, 3'd1, 32'h0003_0000);
    // feed the trend ring a rising ramp
    for (int k = 0; k < 14; k++)
      directed(14'(3700 + 5*k), 14'(3700 + 5*k), 14'(3700 + 5*k), 14'd0, 14'd0, 3'd3,
               32'(100000 * k));
    drain();

    // Phase 1: extreme registers, sender idles 36%, receiver 76%.
    send_idle_pct = 36; recv_idle_pct = 76;
    write_cfg(REG_ALPHA, 100); write_cfg(REG_CHARGING, 0); write_cfg(REG_FULL, 9300);
    write_cfg(REG_PRESENT, 0); write_cfg(REG_RISE, 0); write_cfg(REG_FALL, 32'h7FF);
    write_cfg(REG_FREEZE, 0);
    rand_polls(250);
    drain();
    write_cfg(REG_ALPHA, 0); write_cfg(REG_CHARGING, 9300); write_cfg(REG_FULL, 0);
    write_cfg(REG_PRESENT, 9300); write_cfg(REG_RISE, 1000); write_cfg(REG_FALL, 32'h418);
    write_cfg(REG_FREEZE, 32'hFFFF_FFFF);
    rand_polls(250);
    drain();

    // Phase 2: swapped idle odds, alpha above 100 saturates.
    send_idle_pct = 76; recv_idle_pct = 36;
    write_cfg(REG_ALPHA, 127); write_cfg(REG_CHARGING, 3950); write_cfg(REG_FULL, 4100);
    write_cfg(REG_PRESENT, 3400); write_cfg(REG_RISE, 3); write_cfg(REG_FALL, 32'h7FE);
    write_cfg(REG_FREEZE, 30000);
    write_cfg(REG_NONE, 32'hDEAD_BEEF);
    rand_polls(400);
    drain();

    // Phase 3: no idling, alpha, rise and freeze random in range, the rest at defaults.
    send_idle_pct = 0; recv_idle_pct = 0;
    write_cfg(REG_ALPHA, $urandom_range(100)); write_cfg(REG_CHARGING, 4150);
    write_cfg(REG_FULL, 4200); write_cfg(REG_PRESENT, 2500);
    write_cfg(REG_RISE, $urandom_range(20)); write_cfg(REG_FALL, 32'h7FB);
    write_cfg(REG_FREEZE, $urandom_range(100000));
    rand_polls(725);
    drain();

    if (sb.errors == 0) $display("** battery_soc_estimator_unit: PASSED **");
    else $display("** battery_soc_estimator_unit: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** battery_soc_estimator_unit: FAILED **");
    $finish;
  end
endmodule
